>>> hw/rtl/wppr_pkg.sv
// Shared constants, types and codes for the windowed peak-to-peak rank block.
`default_nettype none

package wppr_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int MAX_RANK       = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int ADDR_BITS      = $clog2(MAX_SAMPLES);
  localparam int CNT_BITS       = ADDR_BITS + 1;
  localparam int RANK_BITS      = $clog2(MAX_RANK);
  localparam int BOUND_BITS     = 11;
  localparam int SUM_BITS       = CNT_BITS + 2;
  localparam int CFG_DATA_BITS  = 11;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS:0]   diff_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;
  typedef logic [ADDR_BITS-1:0]          addr_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;
  typedef logic [RANK_BITS-1:0]          rank_t;
  typedef logic signed [BOUND_BITS-1:0]  bound_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIN_START,
    REG_WIN_END,
    REG_RANK_TOP,
    REG_RANK_BOT
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ERR_OK,
    ERR_EMPTY,
    ERR_RANK
  } err_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RESOLVE,
    ST_CHECK,
    ST_SCAN,
    ST_FIND,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Controls shared by both rank lists.
  typedef struct packed {
    logic    clear;
    logic    ins_en;
    sample_t ins_val;
  } rank_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/wppr_if.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

interface wppr_in_if;
  logic                  valid;
  logic                  ready;
  wppr_pkg::sample_t     sample;
  logic                  last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wppr_out_if;
  logic                  valid;
  logic                  ready;
  wppr_pkg::mag_t        peak_to_peak;
  wppr_pkg::sample_t     high_value;
  wppr_pkg::sample_t     low_value;
  wppr_pkg::addr_t       high_index;
  wppr_pkg::addr_t       low_index;
  wppr_pkg::err_t        error_code;

  modport source (output valid, output peak_to_peak, output high_value, output low_value,
                  output high_index, output low_index, output error_code, input ready);
  modport sink   (input valid, input peak_to_peak, input high_value, input low_value,
                  input high_index, input low_index, input error_code, output ready);
endinterface

interface wppr_cfg_if;
  logic                  valid;
  logic                  ready;
  wppr_pkg::cfg_reg_t    index;
  wppr_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wppr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module wppr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/wppr_rank_list.sv
// Sorted candidate list that keeps the best MAX_RANK values seen in a pass.
`default_nettype none

module wppr_rank_list (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                want_high,
  input  wire wppr_pkg::rank_ctl_t ctl,
  input  wire wppr_pkg::rank_t     rank,
  output      wppr_pkg::sample_t   ranked
);

  wppr_pkg::sample_t                  val_r   [wppr_pkg::MAX_RANK];
  wppr_pkg::sample_t                  val_nxt [wppr_pkg::MAX_RANK];
  logic [wppr_pkg::MAX_RANK-1:0]      vld_r;
  logic [wppr_pkg::MAX_RANK-1:0]      vld_nxt;
  logic [wppr_pkg::MAX_RANK-1:0]      beats;

  // An empty slot or a strictly worse value loses to the incoming one, so an
  // equal value is placed after the entries already holding it.
  always_comb begin
    for (int i = 0; i < wppr_pkg::MAX_RANK; i++) begin
      beats[i] = !vld_r[i] ||
                 (want_high ? (val_r[i] < ctl.ins_val) : (val_r[i] > ctl.ins_val));
    end
  end

  // Insert by shifting every losing entry down one slot.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.clear) begin
      vld_nxt = '0;
    end else if (ctl.ins_en) begin
      val_nxt[0] = beats[0] ? ctl.ins_val : val_r[0];
      for (int i = 1; i < wppr_pkg::MAX_RANK; i++) begin
        if (beats[i]) begin
          val_nxt[i] = beats[i-1] ? val_r[i-1] : ctl.ins_val;
        end
      end
      vld_nxt = vld_r | {vld_r[wppr_pkg::MAX_RANK-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign ranked = val_r[rank];

endmodule

`default_nettype wire

>>> hw/rtl/windowed_peak_to_peak_rank.sv
// Top level of the windowed peak-to-peak detector with rank selection.
//
// Usage: samples of one waveform arrive on the in_chan valid/ready channel,
// one request per cycle, and are written into a 1024-entry sample RAM. The
// request with last_sample set closes the waveform. The block then resolves
// the window, sweeps it once through the RAM read port to fill the top and
// bottom rank lists, and sweeps it again to find the first index of each
// ranked value. One result request leaves on out_chan per waveform.
// An empty window or a rank that is too large skips both sweeps. Both
// sweeps share the single RAM read port, one entry per cycle. Samples load
// at one per cycle; in_chan.ready is low from the last sample until the
// result is in the output register. A result waiting in the output
// register does not block loading of the next waveform; a finished result
// stalls only when the previous one is still untaken. cfg_chan is always
// ready; the user must write it only between waveforms, as the block itself
// does not enforce this. Synchronous reset clears the sample count, the
// sequencer and the output valid flag and loads the register defaults.
`default_nettype none

module windowed_peak_to_peak_rank (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wppr_in_if.sink     in_chan,
  wppr_out_if.source  out_chan,
  wppr_cfg_if.sink    cfg_chan
);

  // Clamp a window bound against the waveform length.
  function automatic wppr_pkg::addr_t clamp_bound(input wppr_pkg::bound_t b,
                                                   input wppr_pkg::cnt_t n);
    wppr_pkg::sum_t nn;
    wppr_pkg::sum_t bb;
    wppr_pkg::sum_t top;
    wppr_pkg::sum_t sum;
    nn  = wppr_pkg::sum_t'(n);
    bb  = wppr_pkg::sum_t'(b);
    top = nn - wppr_pkg::sum_t'(1);
    if (!b[wppr_pkg::BOUND_BITS-1]) begin
      sum = (bb < top) ? bb : top;
    end else begin
      sum = nn + bb;
      if (sum < 0) begin
        sum = '0;
      end
    end
    return sum[wppr_pkg::ADDR_BITS-1:0];
  endfunction

  wppr_pkg::state_t     state_r, state_nxt;

  // Configuration registers.
  wppr_pkg::bound_t     win_start_r, win_start_nxt;
  wppr_pkg::bound_t     win_end_r, win_end_nxt;
  wppr_pkg::rank_t      rank_top_r, rank_top_nxt;
  wppr_pkg::rank_t      rank_bot_r, rank_bot_nxt;

  // Load and window state.
  wppr_pkg::cnt_t       count_r, count_nxt;
  wppr_pkg::cnt_t       n_r, n_nxt;
  wppr_pkg::addr_t      st_r, st_nxt;
  wppr_pkg::addr_t      en_r, en_nxt;
  wppr_pkg::addr_t      ptr_r, ptr_nxt;
  wppr_pkg::err_t       err_r, err_nxt;

  // Read pipeline tags.
  logic                 rd_scan_r, rd_scan_nxt;
  logic                 rd_find_r, rd_find_nxt;
  wppr_pkg::addr_t      rd_idx_r, rd_idx_nxt;

  // First-match search.
  logic                 hfound_r, hfound_nxt;
  logic                 lfound_r, lfound_nxt;
  wppr_pkg::addr_t      hidx_r, hidx_nxt;
  wppr_pkg::addr_t      lidx_r, lidx_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  wppr_pkg::mag_t       out_p2p_r, out_p2p_nxt;
  wppr_pkg::sample_t    out_hi_r, out_hi_nxt;
  wppr_pkg::sample_t    out_lo_r, out_lo_nxt;
  wppr_pkg::addr_t      out_hidx_r, out_hidx_nxt;
  wppr_pkg::addr_t      out_lidx_r, out_lidx_nxt;
  wppr_pkg::err_t       out_err_r, out_err_nxt;

  // Sequencer outputs and datapath nets.
  logic                 in_ready;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 scan_issue;
  logic                 find_issue;
  logic                 list_clear;
  logic                 out_free;
  logic                 emit;
  logic                 full;
  logic                 ptr_at_end;
  logic                 win_empty;
  logic                 rank_err;
  wppr_pkg::cnt_t       wsize;
  wppr_pkg::cnt_t       count_inc;
  wppr_pkg::sample_t    rd_data;
  wppr_pkg::sample_t    high_ranked;
  wppr_pkg::sample_t    low_ranked;
  wppr_pkg::diff_t      diff;
  wppr_pkg::rank_ctl_t  rank_ctl;

  assign in_acc     = in_chan.valid && in_ready;
  assign cfg_acc    = cfg_chan.valid && cfg_chan.ready;
  assign full       = (count_r == wppr_pkg::cnt_t'(wppr_pkg::MAX_SAMPLES));
  assign count_inc  = full ? count_r : count_r + wppr_pkg::cnt_t'(1);
  assign ptr_at_end = (ptr_r == en_r);
  assign out_free   = !out_valid_r || out_chan.ready;

  // Window checks on the clamped bounds.
  assign win_empty = (st_r > en_r);
  assign wsize     = wppr_pkg::cnt_t'(en_r) - wppr_pkg::cnt_t'(st_r) + wppr_pkg::cnt_t'(1);
  assign rank_err  = (wppr_pkg::cnt_t'(rank_top_r) >= wsize) ||
                     (wppr_pkg::cnt_t'(rank_bot_r) >= wsize);

  // Sample store.
  wppr_ram #(
    .WIDTH (wppr_pkg::SAMPLE_BITS),
    .DEPTH (wppr_pkg::MAX_SAMPLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && !full),
    .wr_addr (count_r[wppr_pkg::ADDR_BITS-1:0]),
    .wr_data (in_chan.sample),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  // Both rank lists see every sample of the first sweep.
  assign rank_ctl.clear   = list_clear;
  assign rank_ctl.ins_en  = rd_scan_r;
  assign rank_ctl.ins_val = rd_data;

  wppr_rank_list u_top_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .want_high (1'b1),
    .ctl       (rank_ctl),
    .rank      (rank_top_r),
    .ranked    (high_ranked)
  );

  wppr_rank_list u_bot_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .want_high (1'b0),
    .ctl       (rank_ctl),
    .rank      (rank_bot_r),
    .ranked    (low_ranked)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wppr_pkg::ST_LOAD: begin
        if (in_acc && in_chan.last_sample) begin
          state_nxt = wppr_pkg::ST_RESOLVE;
        end
      end
      wppr_pkg::ST_RESOLVE: begin
        state_nxt = wppr_pkg::ST_CHECK;
      end
      wppr_pkg::ST_CHECK: begin
        state_nxt = (win_empty || rank_err) ? wppr_pkg::ST_EMIT : wppr_pkg::ST_SCAN;
      end
      wppr_pkg::ST_SCAN: begin
        if (ptr_at_end) begin
          state_nxt = wppr_pkg::ST_FIND;
        end
      end
      wppr_pkg::ST_FIND: begin
        if (ptr_at_end) begin
          state_nxt = wppr_pkg::ST_DRAIN;
        end
      end
      wppr_pkg::ST_DRAIN: begin
        state_nxt = wppr_pkg::ST_EMIT;
      end
      wppr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = wppr_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = wppr_pkg::ST_LOAD;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    scan_issue = 1'b0;
    find_issue = 1'b0;
    list_clear = 1'b0;
    emit       = 1'b0;
    case (state_r)
      wppr_pkg::ST_LOAD:  in_ready   = 1'b1;
      wppr_pkg::ST_CHECK: list_clear = 1'b1;
      wppr_pkg::ST_SCAN:  scan_issue = 1'b1;
      wppr_pkg::ST_FIND:  find_issue = 1'b1;
      wppr_pkg::ST_EMIT:  emit       = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Result arithmetic; crossed ranks saturate to zero.
  assign diff = wppr_pkg::diff_t'(high_ranked) - wppr_pkg::diff_t'(low_ranked);

  // Datapath next values.
  always_comb begin
    win_start_nxt = win_start_r;
    win_end_nxt   = win_end_r;
    rank_top_nxt  = rank_top_r;
    rank_bot_nxt  = rank_bot_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    st_nxt        = st_r;
    en_nxt        = en_r;
    ptr_nxt       = ptr_r;
    err_nxt       = err_r;
    rd_scan_nxt   = scan_issue;
    rd_find_nxt   = find_issue;
    rd_idx_nxt    = ptr_r;
    hfound_nxt    = hfound_r;
    lfound_nxt    = lfound_r;
    hidx_nxt      = hidx_r;
    lidx_nxt      = lidx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_p2p_nxt   = out_p2p_r;
    out_hi_nxt    = out_hi_r;
    out_lo_nxt    = out_lo_r;
    out_hidx_nxt  = out_hidx_r;
    out_lidx_nxt  = out_lidx_r;
    out_err_nxt   = out_err_r;

    // Configuration writes.
    if (cfg_acc) begin
      case (cfg_chan.index)
        wppr_pkg::REG_WIN_START: win_start_nxt = cfg_chan.data;
        wppr_pkg::REG_WIN_END:   win_end_nxt   = cfg_chan.data;
        wppr_pkg::REG_RANK_TOP:  rank_top_nxt  = cfg_chan.data[wppr_pkg::RANK_BITS-1:0];
        wppr_pkg::REG_RANK_BOT:  rank_bot_nxt  = cfg_chan.data[wppr_pkg::RANK_BITS-1:0];
        default: begin
          win_start_nxt = win_start_r;
        end
      endcase
    end

    // Sample count; the last sample latches the waveform length.
    if (in_acc) begin
      if (in_chan.last_sample) begin
        n_nxt     = count_inc;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end

    if (state_r == wppr_pkg::ST_RESOLVE) begin
      st_nxt = clamp_bound(win_start_r, n_r);
      en_nxt = clamp_bound(win_end_r, n_r);
    end

    if (list_clear) begin
      err_nxt    = win_empty ? wppr_pkg::ERR_EMPTY :
                   (rank_err ? wppr_pkg::ERR_RANK : wppr_pkg::ERR_OK);
      ptr_nxt    = st_r;
      hfound_nxt = 1'b0;
      lfound_nxt = 1'b0;
      hidx_nxt   = '0;
      lidx_nxt   = '0;
    end

    // Sweep pointer wraps to the window start between the two sweeps.
    if (scan_issue || find_issue) begin
      ptr_nxt = ptr_at_end ? st_r : ptr_r + wppr_pkg::addr_t'(1);
    end

    // First index that holds each ranked value.
    if (rd_find_r) begin
      if (!hfound_r && (rd_data == high_ranked)) begin
        hfound_nxt = 1'b1;
        hidx_nxt   = rd_idx_r;
      end
      if (!lfound_r && (rd_data == low_ranked)) begin
        lfound_nxt = 1'b1;
        lidx_nxt   = rd_idx_r;
      end
    end

    // Load the output register.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_err_nxt   = err_r;
      if (err_r == wppr_pkg::ERR_OK) begin
        out_p2p_nxt  = diff[wppr_pkg::SAMPLE_BITS] ? '0 : diff[wppr_pkg::SAMPLE_BITS-1:0];
        out_hi_nxt   = high_ranked;
        out_lo_nxt   = low_ranked;
        out_hidx_nxt = hidx_r;
        out_lidx_nxt = lidx_r;
      end else begin
        out_p2p_nxt  = '0;
        out_hi_nxt   = '0;
        out_lo_nxt   = '0;
        out_hidx_nxt = '0;
        out_lidx_nxt = '0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wppr_pkg::ST_LOAD;
      win_start_r <= '0;
      win_end_r   <= '1;
      rank_top_r  <= '0;
      rank_bot_r  <= '0;
      count_r     <= '0;
      rd_scan_r   <= 1'b0;
      rd_find_r   <= 1'b0;
      hfound_r    <= 1'b0;
      lfound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
      rank_top_r  <= rank_top_nxt;
      rank_bot_r  <= rank_bot_nxt;
      count_r     <= count_nxt;
      rd_scan_r   <= rd_scan_nxt;
      rd_find_r   <= rd_find_nxt;
      hfound_r    <= hfound_nxt;
      lfound_r    <= lfound_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    st_r       <= st_nxt;
    en_r       <= en_nxt;
    ptr_r      <= ptr_nxt;
    err_r      <= err_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hidx_r     <= hidx_nxt;
    lidx_r     <= lidx_nxt;
    out_p2p_r  <= out_p2p_nxt;
    out_hi_r   <= out_hi_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hidx_r <= out_hidx_nxt;
    out_lidx_r <= out_lidx_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Channel ports.
  assign in_chan.ready         = in_ready;
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.peak_to_peak = out_p2p_r;
  assign out_chan.high_value   = out_hi_r;
  assign out_chan.low_value    = out_lo_r;
  assign out_chan.high_index   = out_hidx_r;
  assign out_chan.low_index    = out_lidx_r;
  assign out_chan.error_code   = out_err_r;

`ifndef SYNTHESIS
  // The sweep pointer never leaves the resolved window.
  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wppr_pkg::ST_SCAN || state_r == wppr_pkg::ST_FIND) |->
      (ptr_r >= st_r && ptr_r <= en_r))
    else $error("sweep pointer outside window");

  // A RAM read belongs to exactly one sweep.
  a_one_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_scan_r && rd_find_r))
    else $error("read tagged for both sweeps");

  // Both ranked values are located before a good result is emitted.
  a_found_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wppr_pkg::ST_EMIT && err_r == wppr_pkg::ERR_OK) |-> (hfound_r && lfound_r))
    else $error("ranked value not located in window");

  // The sample count saturates at the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= wppr_pkg::cnt_t'(wppr_pkg::MAX_SAMPLES))
    else $error("sample count past store depth");
`endif

endmodule

`default_nettype wire

>>> bench/windowed_peak_to_peak_rank_test.sv
// Self-checking testbench for the windowed peak-to-peak rank detector.
`timescale 1ns / 100ps

module windowed_peak_to_peak_rank_test;
  import wppr_pkg::*;

  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 270;

  // One sample request as it waits for the driver.
  typedef struct {
    sample_t value;
    logic    last;
  } sample_req_t;

  // One expected result request.
  typedef struct packed {
    mag_t    peak_to_peak;
    sample_t high_value;
    sample_t low_value;
    addr_t   high_index;
    addr_t   low_index;
    err_t    error_code;
  } p2p_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wppr_in_if  in_chan();
  wppr_out_if out_chan();
  wppr_cfg_if cfg_chan();

  windowed_peak_to_peak_rank dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Stimulus and prediction state.
  sample_req_t pending_samples[$];
  p2p_result_t expected_results[$];
  sample_req_t next_req;
  sample_t     wave_store [MAX_SAMPLES];
  int          wave_len = 0;
  int          shadow_start = 0;
  int          shadow_end = -1;
  int          shadow_rank_top = 0;
  int          shadow_rank_bot = 0;
  int          samples_queued = 0;
  int          samples_taken = 0;
  logic        sample_taken = 1'b0;
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          result_hold_left = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Map a window bound onto the waveform, counting back from its length when negative.
  function automatic int clamp_bound(int b, int n);
    if (b >= 0) return (b < n - 1) ? b : n - 1;
    return (n + b < 0) ? 0 : n + b;
  endfunction

  // First window index whose value sits at the given rank, duplicates counted apart.
  function automatic int ranked_position(int lo_b, int hi_b, int rank, bit from_top);
    int ahead;
    int tied;
    for (int i = lo_b; i <= hi_b; i++) begin
      ahead = 0;
      tied = 0;
      for (int j = lo_b; j <= hi_b; j++) begin
        if (from_top ? (wave_store[j] > wave_store[i]) : (wave_store[j] < wave_store[i]))
          ahead++;
        else if (wave_store[j] == wave_store[i])
          tied++;
      end
      if (ahead <= rank && rank < ahead + tied) return i;
    end
    return lo_b;
  endfunction

  // Resolve the window of the waveform just closed into its expected result.
  function automatic p2p_result_t resolve_window();
    p2p_result_t r;
    int lo_b;
    int hi_b;
    int span;
    int hi_at;
    int lo_at;
    int diff;
    r = '0;
    lo_b = clamp_bound(shadow_start, wave_len);
    hi_b = clamp_bound(shadow_end, wave_len);
    if (lo_b > hi_b) begin
      r.error_code = ERR_EMPTY;
      return r;
    end
    span = hi_b - lo_b + 1;
    if (shadow_rank_top >= span || shadow_rank_bot >= span ||
        shadow_rank_top >= MAX_RANK || shadow_rank_bot >= MAX_RANK) begin
      r.error_code = ERR_RANK;
      return r;
    end
    hi_at = ranked_position(lo_b, hi_b, shadow_rank_top, 1'b1);
    lo_at = ranked_position(lo_b, hi_b, shadow_rank_bot, 1'b0);
    r.high_value = wave_store[hi_at];
    r.low_value = wave_store[lo_at];
    r.high_index = addr_t'(hi_at);
    r.low_index = addr_t'(lo_at);
    diff = int'(r.high_value) - int'(r.low_value);
    // Crossed ranks saturate to zero.
    r.peak_to_peak = (diff < 0) ? '0 : mag_t'(diff);
    r.error_code = ERR_OK;
    return r;
  endfunction

  // Store a sample; the closing one yields a result.
  task automatic absorb_sample(sample_t v, logic last);
    if (wave_len < MAX_SAMPLES) begin
      wave_store[wave_len] = v;
      wave_len++;
    end
    if (last) begin
      expected_results.push_back(resolve_window());
      wave_len = 0;
    end
  endtask

  task automatic check_result();
    p2p_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected, peak_to_peak %0d",
                                out_chan.peak_to_peak));
      return;
    end
    want = expected_results.pop_front();
    if (out_chan.peak_to_peak !== want.peak_to_peak)
      report_mismatch($sformatf("peak_to_peak got %0d want %0d",
                                out_chan.peak_to_peak, want.peak_to_peak));
    if (out_chan.high_value !== want.high_value)
      report_mismatch($sformatf("high_value got %0d want %0d",
                                out_chan.high_value, want.high_value));
    if (out_chan.low_value !== want.low_value)
      report_mismatch($sformatf("low_value got %0d want %0d",
                                out_chan.low_value, want.low_value));
    if (out_chan.high_index !== want.high_index)
      report_mismatch($sformatf("high_index got %0d want %0d",
                                out_chan.high_index, want.high_index));
    if (out_chan.low_index !== want.low_index)
      report_mismatch($sformatf("low_index got %0d want %0d",
                                out_chan.low_index, want.low_index));
    if (out_chan.error_code !== want.error_code)
      report_mismatch($sformatf("error_code got %0d want %0d",
                                out_chan.error_code, want.error_code));
  endtask

  // Monitor: accepted samples feed the predictor, accepted results are checked.
  always @(posedge clk) begin
    sample_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      samples_taken++;
      absorb_sample(in_chan.sample, in_chan.last_sample);
    end
    if (rst_n && out_chan.valid && out_chan.ready)
      check_result();
  end

  // Watchdog: too long without any accepted request ends the run.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[windowed_peak_to_peak_rank] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sample driver: hold a request until taken, then offer the next one or idle.
  always @(negedge clk) begin
    if (rst_n && (!in_chan.valid || sample_taken)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_samples.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.sample <= next_req.value;
        in_chan.last_sample <= next_req.last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(negedge clk) begin
    if (!rst_n || result_hold_left != 0)
      out_chan.ready <= 1'b0;
    else
      out_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Count down the long hold-off on the result side.
  always @(negedge clk) begin
    if (result_hold_left != 0) result_hold_left <= result_hold_left - 1;
  end

  task automatic push_sample(sample_t v, logic last);
    sample_req_t req;
    req.value = v;
    req.last = last;
    pending_samples.push_back(req);
    samples_queued++;
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return sample_t'(32767);
      1:       return sample_t'(-32768);
      2, 3:    return sample_t'(int'($urandom_range(8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_waveform(int len);
    for (int i = 0; i < len; i++) push_sample(random_sample(), i == len - 1);
  endtask

  // Wait until every sample is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (samples_taken != samples_queued || expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t which, int value);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= which;
    cfg_chan.data <= cfg_data_t'(value);
    do @(posedge clk); while (!cfg_chan.ready);
    case (which)
      REG_WIN_START: shadow_start = bound_t'(cfg_chan.data);
      REG_WIN_END:   shadow_end = bound_t'(cfg_chan.data);
      REG_RANK_TOP:  shadow_rank_top = int'(cfg_chan.data[RANK_BITS-1:0]);
      REG_RANK_BOT:  shadow_rank_bot = int'(cfg_chan.data[RANK_BITS-1:0]);
      default: ;
    endcase
  endtask

  // Reconfigure only once the block has gone idle.
  task automatic set_window_and_ranks(int s, int e, int t, int b);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_WIN_START, s);
    write_register(REG_WIN_END, e);
    write_register(REG_RANK_TOP, t);
    write_register(REG_RANK_BOT, b);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One random setting followed by a few waveforms; returns the samples pushed.
  task automatic random_segment(output int pushed);
    int s;
    int e;
    int t;
    int b;
    int len;
    pushed = 0;
    case ($urandom_range(9))
      0: begin
        // Noise: any setting at all, often empty or with ranks too large.
        s = int'($urandom_range(2047)) - 1024;
        e = int'($urandom_range(2047)) - 1024;
        t = $urandom_range(15);
        b = $urandom_range(15);
      end
      1: begin
        s = ($urandom_range(1) != 0) ? -1024 : 0;
        e = ($urandom_range(1) != 0) ? 1023 : -1;
        t = 15;
        b = $urandom_range(15);
      end
      default: begin
        s = ($urandom_range(1) != 0) ? int'($urandom_range(4)) : -int'($urandom_range(40, 20));
        e = ($urandom_range(1) != 0) ? -1 - int'($urandom_range(3)) : 1023;
        t = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
        b = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
      end
    endcase
    set_window_and_ranks(s, e, t, b);
    repeat ($urandom_range(2, 6)) begin
      len = ((t > b) ? t : b) + 9 + $urandom_range(24);
      if ($urandom_range(15) == 0) len += $urandom_range(300);
      if ($urandom_range(19) == 0) len = $urandom_range(1, 3);
      push_waveform(len);
      pushed += len;
    end
  endtask

  initial begin : stimulus
    int phase_items;
    int total_items;
    int pushed;
    in_chan.valid = 1'b0;
    in_chan.sample = '0;
    in_chan.last_sample = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_WIN_START;
    cfg_chan.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings: single sample, full-scale swing,
    // repeated extremes that must report their first index.
    push_sample(sample_t'(32767), 1'b1);
    push_sample(sample_t'(-32768), 1'b0);
    push_sample(sample_t'(32767), 1'b1);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(-3), 1'b0);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(-3), 1'b1);
    // Crossed ranks saturate the difference to zero.
    set_window_and_ranks(0, -1, 1, 1);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(1), 1'b1);
    // A rank as large as the window is flagged.
    set_window_and_ranks(0, -1, 2, 0);
    push_sample(sample_t'(3), 1'b0);
    push_sample(sample_t'(4), 1'b1);
    // Start past end leaves an empty window.
    set_window_and_ranks(3, 1, 0, 0);
    for (int i = 1; i <= 5; i++) push_sample(sample_t'(i), i == 5);
    // Bounds at both extremes get clamped to the waveform.
    set_window_and_ranks(-1024, 1023, 0, 0);
    push_sample(sample_t'(-7), 1'b0);
    push_sample(sample_t'(100), 1'b0);
    push_sample(sample_t'(-7), 1'b0);
    push_sample(sample_t'(100), 1'b1);
    // Largest rank on a short tail window.
    set_window_and_ranks(-2, -1, 0, 15);
    push_sample(sample_t'(9), 1'b0);
    push_sample(sample_t'(8), 1'b0);
    push_sample(sample_t'(7), 1'b1);

    // Store overflow: samples past the last store entry are dropped, and the
    // maximum sits in that last entry.
    set_window_and_ranks(0, 1023, 0, 15);
    for (int i = 0; i < MAX_SAMPLES + 6; i++) begin
      if (i < MAX_SAMPLES - 1)
        push_sample(sample_t'(int'($urandom_range(2000)) - 1000), 1'b0);
      else if (i == MAX_SAMPLES - 1)
        push_sample(sample_t'(32767), 1'b0);
      else
        push_sample(sample_t'(-32768), i == MAX_SAMPLES + 5);
    end

    // Random part in three stall profiles.
    total_items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 63 : 0;
      receiver_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 7 : 0;
      phase_items = 0;
      if (phase == 0) begin
        // Hold results back while waveforms keep coming, so the input stalls.
        set_window_and_ranks(0, -1, 1, 2);
        result_hold_left <= HOLD_CYCLES;
        repeat (8) begin
          pushed = $urandom_range(6, 12);
          push_waveform(pushed);
          phase_items += pushed;
        end
      end
      while (phase_items < RANDOM_ITEMS / 3) begin
        random_segment(pushed);
        phase_items += pushed;
      end
      total_items += phase_items;
    end

    wait_drained();
    repeat (2 * MAX_SAMPLES + 8) @(posedge clk);
    if (mismatches == 0)
      $display("[windowed_peak_to_peak_rank] OK");
    else
      $display("[windowed_peak_to_peak_rank] ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wppr_pkg.sv
hw/rtl/wppr_if.sv
hw/rtl/wppr_ram.sv
hw/rtl/wppr_rank_list.sv
hw/rtl/windowed_peak_to_peak_rank.sv
bench/windowed_peak_to_peak_rank_test.sv
